FILE: src/stap_pkg.sv
// Shared widths, constants, types and the arctangent table for the spherical triangle area block.
package stap_pkg;

    localparam int CORDIC_STEPS = 32;

    localparam int SIDE_W     = 32;                 // input side, Q2.30
    localparam int ANG_W      = 36;                 // angle sums, units of 2^-31 rad
    localparam int SIN_W      = 34;                 // sine results, Q.30
    localparam int ZW         = 35;                 // CORDIC angle accumulators
    localparam int AW         = 36;                 // vectoring x/y
    localparam int K_W        = 64;                 // product term k
    localparam int ROOT_W     = K_W / 2;            // sqrt(k << e)
    localparam int SH_W       = 4;                  // sine rescale shift
    localparam int ZS_W       = ZW + 2;             // sum of three angles
    localparam int AREA_CALC_W = 40;                // 2*sum - pi before rounding
    localparam int AREA_W     = 32;                 // Q3.29 result
    localparam int FRAC_SHIFT = 30;

    localparam logic signed [ANG_W-1:0] PI31      = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] TWO_PI31  = 36'sd13493037705;
    localparam logic signed [ANG_W-1:0] HALF_PI31 = 36'sd3373259426;
    localparam logic signed [SIN_W-1:0] GAIN_Q30  = 34'sd652032874;

    typedef logic signed [SIN_W-1:0] sin_t;

    typedef struct packed {
        sin_t s0;   // sin(s-a)
        sin_t s1;   // sin(s-b)
        sin_t s2;   // sin(s-c)
    } sines_t;

    typedef struct packed {
        logic   deg;
        sines_t sv;
    } side_t;

    // atan(2^-i) in units of 2^-31 rad
    function automatic logic signed [ZW-1:0] cordic_angle(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        case (i)
            0:  r = 35'sd1686629713;
            1:  r = 35'sd995675659;
            2:  r = 35'sd526087673;
            3:  r = 35'sd267050318;
            4:  r = 35'sd134043374;
            5:  r = 35'sd67087032;
            6:  r = 35'sd33551702;
            7:  r = 35'sd16776874;
            8:  r = 35'sd8388566;
            9:  r = 35'sd4194298;
            10: r = 35'sd2097152;
            default: begin
                if (i < 32) begin
                    r = ZW'(longint'(1) << (31 - i));
                end
            end
        endcase
        return r;
    endfunction

endpackage

FILE: src/stap_sin4.sv
// Four-lane angle reduction and rotation CORDIC: sin(s), sin(s-a), sin(s-b), sin(s-c).
module stap_sin4 (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_vld,
    input  logic [stap_pkg::SIDE_W-1:0]           side_a,
    input  logic [stap_pkg::SIDE_W-1:0]           side_b,
    input  logic [stap_pkg::SIDE_W-1:0]           side_c,
    output logic                                  out_vld,
    output stap_pkg::sines_t                      sv,
    output stap_pkg::sin_t                        ss
);

    localparam int S = stap_pkg::CORDIC_STEPS;
    localparam int L = 4;
    localparam int AWD = stap_pkg::ANG_W;
    localparam int SW = stap_pkg::SIN_W;
    localparam int ZWD = stap_pkg::ZW;

    logic signed [AWD-1:0] ea, eb, ec;
    logic signed [AWD-1:0] ang_in [L];
    logic signed [AWD-1:0] ang_reg [L];
    logic signed [AWD-1:0] wrap_reg [L];
    logic signed [SW-1:0]  x_reg [0:S][L];
    logic signed [SW-1:0]  y_reg [0:S][L];
    logic signed [ZWD-1:0] z_reg [0:S][L];
    logic                  v_reg [0:S+2];

    assign ea = $signed({{(AWD-stap_pkg::SIDE_W){1'b0}}, side_a});
    assign eb = $signed({{(AWD-stap_pkg::SIDE_W){1'b0}}, side_b});
    assign ec = $signed({{(AWD-stap_pkg::SIDE_W){1'b0}}, side_c});

    // lane 0: 2s, lanes 1..3: 2(s-a), 2(s-b), 2(s-c) in Q2.30 = s terms in 2^-31
    assign ang_in[0] = ea + eb + ec;
    assign ang_in[1] = eb + ec - ea;
    assign ang_in[2] = ea + ec - eb;
    assign ang_in[3] = ea + eb - ec;

    for (genvar l = 0; l < L; l++) begin : g_front
        logic signed [AWD-1:0] wrap_next, fold_next;

        always_comb begin
            if (ang_reg[l] > stap_pkg::PI31) begin
                wrap_next = ang_reg[l] - stap_pkg::TWO_PI31;
            end else if (ang_reg[l] < -stap_pkg::PI31) begin
                wrap_next = ang_reg[l] + stap_pkg::TWO_PI31;
            end else begin
                wrap_next = ang_reg[l];
            end
        end

        // sin(x) = sin(pi - x) folds into [-pi/2, pi/2]
        always_comb begin
            if (wrap_reg[l] > stap_pkg::HALF_PI31) begin
                fold_next = stap_pkg::PI31 - wrap_reg[l];
            end else if (wrap_reg[l] < -stap_pkg::HALF_PI31) begin
                fold_next = -stap_pkg::PI31 - wrap_reg[l];
            end else begin
                fold_next = wrap_reg[l];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ang_reg[l]  <= ang_in[l];
                wrap_reg[l] <= wrap_next;
                x_reg[0][l] <= stap_pkg::GAIN_Q30;
                y_reg[0][l] <= '0;
                z_reg[0][l] <= ZWD'(fold_next);
            end
        end
    end

    for (genvar i = 0; i < S; i++) begin : g_step
        for (genvar l = 0; l < L; l++) begin : g_lane
            logic signed [SW-1:0] dx, dy;
            assign dx = y_reg[i][l] >>> i;
            assign dy = x_reg[i][l] >>> i;

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!z_reg[i][l][ZWD-1]) begin
                        x_reg[i+1][l] <= x_reg[i][l] - dx;
                        y_reg[i+1][l] <= y_reg[i][l] + dy;
                        z_reg[i+1][l] <= z_reg[i][l] - stap_pkg::cordic_angle(i);
                    end else begin
                        x_reg[i+1][l] <= x_reg[i][l] + dx;
                        y_reg[i+1][l] <= y_reg[i][l] - dy;
                        z_reg[i+1][l] <= z_reg[i][l] + stap_pkg::cordic_angle(i);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n <= S + 2; n++) begin
                v_reg[n] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_vld;
            for (int n = 1; n <= S + 2; n++) begin
                v_reg[n] <= v_reg[n-1];
            end
        end
    end

    assign out_vld = v_reg[S+2];
    assign ss      = y_reg[S][0];
    assign sv.s0   = y_reg[S][1];
    assign sv.s1   = y_reg[S][2];
    assign sv.s2   = y_reg[S][3];

endmodule

FILE: src/stap_kdiv.sv
// Product of the three side sines, pipelined restoring divide by sin(s), degenerate test.
module stap_kdiv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  stap_pkg::sines_t              sv,
    input  stap_pkg::sin_t                ss,
    input  logic [31:0]                   thr,
    output logic                          out_vld,
    output logic [stap_pkg::K_W-1:0]      k,
    output stap_pkg::side_t               side
);

    localparam int SW    = stap_pkg::SIN_W;
    localparam int KW    = stap_pkg::K_W;
    localparam int DIV_W = KW;
    localparam int P1_W  = 2 * SW;
    localparam int Q1_W  = P1_W - stap_pkg::FRAC_SHIFT;
    localparam int P2_W  = Q1_W + SW;
    localparam int REM_W = SW;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [KW-1:0]     num;
        logic [KW-1:0]     quo;
        logic [REM_W-1:0]  den;
        logic              neg;
        logic              zero;
        stap_pkg::sines_t  sv;
    } div_t;

    logic signed [P1_W-1:0] p1_reg, p1_next;
    logic signed [P2_W-1:0] p2_reg, p2_next;
    logic signed [Q1_W-1:0] q1;
    stap_pkg::sin_t         ss1_reg, ss2_reg;
    stap_pkg::sines_t       sv1_reg, sv2_reg;
    stap_pkg::sin_t         m0, m1, m2;
    div_t                   dv_reg [0:DIV_W];
    div_t                   dv0_next;
    logic [KW-1:0]          k_reg;
    stap_pkg::side_t        side_reg, side_next;
    logic                   v_reg [0:DIV_W+3];

    assign m0 = sv.s0;
    assign m1 = sv.s1;
    assign m2 = sv1_reg.s2;

    assign p1_next = m0 * m1;
    assign q1      = Q1_W'(p1_reg >>> stap_pkg::FRAC_SHIFT);
    assign p2_next = q1 * m2;

    // magnitudes for the unsigned divider, truncating toward zero; a negative sign marks degenerate
    always_comb begin
        dv0_next.rem  = '0;
        dv0_next.num  = p2_reg[P2_W-1] ? KW'(-p2_reg) : KW'(p2_reg);
        dv0_next.quo  = '0;
        dv0_next.den  = ss2_reg[SW-1] ? REM_W'(-ss2_reg) : REM_W'(ss2_reg);
        dv0_next.neg  = p2_reg[P2_W-1] ^ ss2_reg[SW-1];
        dv0_next.zero = (ss2_reg == '0);
        dv0_next.sv   = sv2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= p1_next;
            ss1_reg   <= ss;
            sv1_reg   <= sv;
            p2_reg    <= p2_next;
            ss2_reg   <= ss1_reg;
            sv2_reg   <= sv1_reg;
            dv_reg[0] <= dv0_next;
        end
    end

    for (genvar i = 0; i < DIV_W; i++) begin : g_div
        logic [REM_W:0] t;
        logic           ge;
        div_t           d_next;

        assign t  = {dv_reg[i].rem, dv_reg[i].num[KW-1]};
        assign ge = (t >= {1'b0, dv_reg[i].den});

        always_comb begin
            d_next     = dv_reg[i];
            d_next.rem = ge ? REM_W'(t - {1'b0, dv_reg[i].den}) : REM_W'(t);
            d_next.num = dv_reg[i].num << 1;
            d_next.quo = {dv_reg[i].quo[KW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[i+1] <= d_next;
            end
        end
    end

    always_comb begin
        side_next.sv  = dv_reg[DIV_W].sv;
        side_next.deg = dv_reg[DIV_W].zero || dv_reg[DIV_W].neg ||
                        (dv_reg[DIV_W].quo == '0) || (dv_reg[DIV_W].quo < KW'(thr));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg    <= dv_reg[DIV_W].quo;
            side_reg <= side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n <= DIV_W + 3; n++) begin
                v_reg[n] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_vld;
            for (int n = 1; n <= DIV_W + 3; n++) begin
                v_reg[n] <= v_reg[n-1];
            end
        end
    end

    assign out_vld = v_reg[DIV_W+3];
    assign k       = k_reg;
    assign side    = side_reg;

endmodule

FILE: src/stap_isqrt.sv
// Normalizing shift and pipelined integer square root of k.
module stap_isqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_vld,
    input  logic [stap_pkg::K_W-1:0]        k,
    input  stap_pkg::side_t                 side_in,
    output logic                            out_vld,
    output logic [stap_pkg::ROOT_W-1:0]     root,
    output logic [stap_pkg::SH_W-1:0]       sh,
    output stap_pkg::side_t                 side_out
);

    localparam int KW  = stap_pkg::K_W;
    localparam int NSQ = KW / 2;
    localparam int JN  = 16;          // even shifts 0..30
    localparam int JW  = $clog2(JN);

    typedef struct packed {
        logic [KW-1:0]                 v;
        logic [KW-1:0]                 res;
        logic [stap_pkg::SH_W-1:0]     sh;
        stap_pkg::side_t               side;
    } sq_t;

    logic [KW-1:0]    ka_reg;
    logic [JN-1:0]    fit_reg, fit_next;
    stap_pkg::side_t  sa_reg;
    logic [JW-1:0]    jsel;
    sq_t              sq0_next;
    sq_t              sq_reg [0:NSQ];
    logic             v_reg [0:NSQ+1];

    // fit[j]: k << 2j stays below 2^62
    always_comb begin
        fit_next[0] = 1'b1;
        for (int j = 1; j < JN; j++) begin
            fit_next[j] = ((k >> (KW - 2 - 2 * j)) == '0);
        end
    end

    always_comb begin
        jsel = '0;
        for (int j = 0; j < JN; j++) begin
            if (fit_reg[j]) begin
                jsel = JW'(j);
            end
        end
        sq0_next.v    = ka_reg << {jsel, 1'b0};
        sq0_next.res  = '0;
        sq0_next.sh   = stap_pkg::SH_W'(JN - 1) - stap_pkg::SH_W'(jsel);
        sq0_next.side = sa_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ka_reg    <= k;
            fit_reg   <= fit_next;
            sa_reg    <= side_in;
            sq_reg[0] <= sq0_next;
        end
    end

    for (genvar j = 0; j < NSQ; j++) begin : g_sq
        localparam logic [KW-1:0] BIT = KW'(1) << (KW - 2 - 2 * j);
        logic [KW:0] trial;
        logic        ge;
        sq_t         s_next;

        assign trial = {1'b0, sq_reg[j].res} + {1'b0, BIT};
        assign ge    = ({1'b0, sq_reg[j].v} >= trial);

        always_comb begin
            s_next = sq_reg[j];
            if (ge) begin
                s_next.v   = sq_reg[j].v - trial[KW-1:0];
                s_next.res = (sq_reg[j].res >> 1) + BIT;
            end else begin
                s_next.res = sq_reg[j].res >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg[j+1] <= s_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n <= NSQ + 1; n++) begin
                v_reg[n] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_vld;
            for (int n = 1; n <= NSQ + 1; n++) begin
                v_reg[n] <= v_reg[n-1];
            end
        end
    end

    assign out_vld  = v_reg[NSQ+1];
    assign root     = sq_reg[NSQ].res[stap_pkg::ROOT_W-1:0];
    assign sh       = sq_reg[NSQ].sh;
    assign side_out = sq_reg[NSQ].side;

endmodule

FILE: src/stap_atan3.sv
// Three-lane vectoring CORDIC for the half angles, then their sum.
module stap_atan3 (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic [stap_pkg::ROOT_W-1:0]       root,
    input  logic [stap_pkg::SH_W-1:0]         sh,
    input  stap_pkg::side_t                   side,
    output logic                              out_vld,
    output logic signed [stap_pkg::ZS_W-1:0]  zsum,
    output logic                              deg
);

    localparam int S   = stap_pkg::CORDIC_STEPS;
    localparam int L   = 3;
    localparam int SW  = stap_pkg::SIN_W;
    localparam int AWD = stap_pkg::AW;
    localparam int ZWD = stap_pkg::ZW;
    localparam int ZSW = stap_pkg::ZS_W;

    stap_pkg::sin_t        sv_in [L];
    logic signed [AWD-1:0] x_reg [0:S][L];
    logic signed [AWD-1:0] y_reg [0:S][L];
    logic signed [ZWD-1:0] z_reg [0:S][L];
    logic signed [ZSW-1:0] zs_reg;
    logic                  deg_reg [0:S+1];
    logic                  v_reg [0:S+1];

    assign sv_in[0] = side.sv.s0;
    assign sv_in[1] = side.sv.s1;
    assign sv_in[2] = side.sv.s2;

    for (genvar l = 0; l < L; l++) begin : g_prep
        logic [SW-1:0]         xs;
        logic signed [AWD-1:0] r;

        assign xs = sv_in[l][SW-1] ? SW'(-sv_in[l]) : SW'(sv_in[l]);
        assign r  = $signed(AWD'(root));

        // negative sine flips the sign of the arctangent
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[0][l] <= $signed(AWD'(xs >> sh));
                y_reg[0][l] <= sv_in[l][SW-1] ? -r : r;
                z_reg[0][l] <= '0;
            end
        end
    end

    for (genvar i = 0; i < S; i++) begin : g_step
        for (genvar l = 0; l < L; l++) begin : g_lane
            logic signed [AWD-1:0] dx, dy;
            assign dx = y_reg[i][l] >>> i;
            assign dy = x_reg[i][l] >>> i;

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!y_reg[i][l][AWD-1]) begin
                        x_reg[i+1][l] <= x_reg[i][l] + dx;
                        y_reg[i+1][l] <= y_reg[i][l] - dy;
                        z_reg[i+1][l] <= z_reg[i][l] + stap_pkg::cordic_angle(i);
                    end else begin
                        x_reg[i+1][l] <= x_reg[i][l] - dx;
                        y_reg[i+1][l] <= y_reg[i][l] + dy;
                        z_reg[i+1][l] <= z_reg[i][l] - stap_pkg::cordic_angle(i);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zs_reg <= ZSW'(z_reg[S][0]) + ZSW'(z_reg[S][1]) + ZSW'(z_reg[S][2]);
            deg_reg[0] <= side.deg;
            for (int n = 1; n <= S + 1; n++) begin
                deg_reg[n] <= deg_reg[n-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n <= S + 1; n++) begin
                v_reg[n] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_vld;
            for (int n = 1; n <= S + 1; n++) begin
                v_reg[n] <= v_reg[n-1];
            end
        end
    end

    assign out_vld = v_reg[S+1];
    assign zsum    = zs_reg;
    assign deg     = deg_reg[S+1];

endmodule

FILE: src/spherical_triangle_area_top.sv
// Throughput: one transfer per cycle; the 64-stage divider, the 32-stage square root and the
//   two CORDIC chains are fully pipelined, so no unit is shared between items.
// Backpressure: m_tready low with a result held stalls every stage at once; nothing is lost.
// Reset: aresetn low (synchronous) clears all valid bits and sets the threshold to 1.
// Spherical triangle area top level: side sines, k, sqrt, half angles, excess.
module spherical_triangle_area_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,     // degenerate_threshold, Q2.30
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,       // [31:0] side_a, [63:32] side_b, [95:64] side_c
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [31:0] tri_area, Q3.29
    output logic        m_tuser        // [0] degenerate
);

    localparam int CW = stap_pkg::AREA_CALC_W;

    // Pipeline advance: the whole chain moves whenever the output register is
    // free or being drained this cycle.
    logic en;

    logic [31:0] thr_reg;

    // sine stage
    logic                 sin_vld;
    stap_pkg::sines_t     sin_sv;
    stap_pkg::sin_t       sin_ss;

    // k stage
    logic                          k_vld;
    logic [stap_pkg::K_W-1:0]      k_val;
    stap_pkg::side_t               k_side;

    // root stage
    logic                          r_vld;
    logic [stap_pkg::ROOT_W-1:0]   r_root;
    logic [stap_pkg::SH_W-1:0]     r_sh;
    stap_pkg::side_t               r_side;

    // angle sum stage
    logic                              a_vld;
    logic signed [stap_pkg::ZS_W-1:0]  a_zsum;
    logic                              a_deg;

    logic signed [CW-1:0] excess2;
    logic signed [CW-1:0] area_q;
    logic [stap_pkg::AREA_W-1:0] area_next;

    logic                         m_tvalid_reg;
    logic [stap_pkg::AREA_W-1:0]  m_tdata_reg;
    logic                         m_tuser_reg;

    assign en       = m_tready || !m_tvalid_reg;
    assign s_tready = en;

    // Threshold register; write only while the pipeline is empty (the block does not enforce it).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 32'd1;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // sin(s), sin(s-a), sin(s-b), sin(s-c)
    stap_sin4 u_sin (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .side_a  (s_tdata[31:0]),
        .side_b  (s_tdata[63:32]),
        .side_c  (s_tdata[95:64]),
        .out_vld (sin_vld),
        .sv      (sin_sv),
        .ss      (sin_ss)
    );

    // k = sin(s-a) sin(s-b) sin(s-c) / sin(s), plus the degenerate decision
    stap_kdiv u_kdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (sin_vld),
        .sv      (sin_sv),
        .ss      (sin_ss),
        .thr     (thr_reg),
        .out_vld (k_vld),
        .k       (k_val),
        .side    (k_side)
    );

    // sqrt(k << e), e even, plus the matching shift for the sines
    stap_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (k_vld),
        .k        (k_val),
        .side_in  (k_side),
        .out_vld  (r_vld),
        .root     (r_root),
        .sh       (r_sh),
        .side_out (r_side)
    );

    // sum of atan(sqrt(k) / sin(s-x)) over the three sides
    stap_atan3 u_atan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (r_vld),
        .root    (r_root),
        .sh      (r_sh),
        .side    (r_side),
        .out_vld (a_vld),
        .zsum    (a_zsum),
        .deg     (a_deg)
    );

    // Excess = 2*sum - pi in 2^-31 units, rounded to Q3.29, clamped to
    // [0, 2^32-1]. Rejected triangles report zero.
    assign excess2 = (CW'(a_zsum) <<< 1) - CW'(stap_pkg::PI31) + 40'sd2;
    assign area_q  = excess2 >>> 2;

    always_comb begin
        if (a_deg || area_q < 0) begin
            area_next = '0;
        end else if (area_q > 40'sd4294967295) begin
            area_next = '1;
        end else begin
            area_next = area_q[stap_pkg::AREA_W-1:0];
        end
    end

    // Output register: holds a finished transfer until m_tready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= a_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= area_next;
            m_tuser_reg <= a_deg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero area");

    a_rst_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid survived reset");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && a_vld) |=> m_tvalid)
        else $error("finished item not loaded into output register");
`endif

endmodule

FILE: bench/spherical_triangle_area_top_tb.sv
// Testbench for spherical_triangle_area_top: random streams checked against a bit-true predictor.
`timescale 1ns / 100ps

module spherical_triangle_area_top_tb;

    localparam int  LATENCY    = 2 * stap_pkg::CORDIC_STEPS + 108;
    localparam int  CYCLE_MAX  = 400000;
    localparam int  RAND_ITEMS = 650;
    localparam int  PHASES     = 6;
    localparam longint SIDE_PI = 64'd3373259426;    // pi in Q2.30

    // Expected result of one triangle
    typedef struct {
        logic [31:0] area;
        logic        deg;
    } area_result_t;

    // Predicts area and degenerate flag; holds the expected transfers in order
    class area_scoreboard;
        area_result_t pending[$];
        longint unsigned threshold;
        int mismatches;

        function new();
            threshold = 1;
            mismatches = 0;
        endfunction

        function longint step_angle(int i);
            longint lo[11] = '{1686629713, 995675659, 526087673, 267050318, 134043374,
                               67087032, 33551702, 16776874, 8388566, 4194298, 2097152};
            if (i < 11) return lo[i];
            if (i < 32) return longint'(1) << (31 - i);
            return 0;
        endfunction

        // Rotation CORDIC sine; angle in 2^-31 rad, result Q.30
        function longint sine_q30(longint ang);
            longint pi_v, x, y, z, dx, dy;
            pi_v = longint'(stap_pkg::PI31);
            x = longint'(stap_pkg::GAIN_Q30);
            y = 0;
            if (ang > pi_v) ang -= longint'(stap_pkg::TWO_PI31);
            else if (ang < -pi_v) ang += longint'(stap_pkg::TWO_PI31);
            if (ang > longint'(stap_pkg::HALF_PI31)) ang = pi_v - ang;
            else if (ang < -longint'(stap_pkg::HALF_PI31)) ang = -pi_v - ang;
            z = ang;
            for (int i = 0; i < stap_pkg::CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= step_angle(i);
                end else begin
                    x += dx; y -= dy; z += step_angle(i);
                end
            end
            return y;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Vectoring CORDIC: atan(y/x), x >= 0, in 2^-31 rad
        function longint vector_atan(longint x, longint y);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < stap_pkg::CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += step_angle(i);
                end else begin
                    x -= dx; y += dy; z -= step_angle(i);
                end
            end
            return z;
        endfunction

        function area_result_t predict_area(logic [31:0] sa, logic [31:0] sb, logic [31:0] sc);
            area_result_t r;
            longint a, b, c, ss, k, root, sum, area, mag;
            longint sv[3];
            int e, sh;
            a = longint'({32'd0, sa});
            b = longint'({32'd0, sb});
            c = longint'({32'd0, sc});
            ss = sine_q30(a + b + c);
            sv[0] = sine_q30(b + c - a);
            sv[1] = sine_q30(a + c - b);
            sv[2] = sine_q30(a + b - c);
            r.area = '0;
            r.deg = 1'b1;
            if (ss == 0) return r;
            k = (((sv[0] * sv[1]) >>> 30) * sv[2]) / ss;
            if (k <= 0 || unsigned'(k) < threshold)
                return r;
            e = 30;
            while (e > 0 && (unsigned'(k) >> (62 - e)) != 0) e -= 2;
            root = longint'(floor_sqrt(unsigned'(k) << e));
            sh = 15 - e / 2;
            sum = 0;
            for (int j = 0; j < 3; j++) begin
                mag = sv[j] < 0 ? -sv[j] : sv[j];
                sum += vector_atan(mag >>> sh, sv[j] < 0 ? -root : root);
            end
            area = (2 * sum - longint'(stap_pkg::PI31) + 2) >>> 2;
            if (area < 0) area = 0;
            if (area > 64'sh0_FFFF_FFFF) area = 64'sh0_FFFF_FFFF;
            r.area = area[31:0];
            r.deg = 1'b0;
            return r;
        endfunction

        function void note_input(logic [95:0] sides);
            pending.push_back(predict_area(sides[31:0], sides[63:32], sides[95:64]));
        endfunction

        function void check_result(logic [31:0] area, logic deg);
            area_result_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: area=%h deg=%b", area, deg);
                return;
            end
            exp_r = pending.pop_front();
            if (area !== exp_r.area || deg !== exp_r.deg) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: area exp %h got %h, deg exp %b got %b",
                             exp_r.area, area, exp_r.deg, deg);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;       // [31:0] side_a, [63:32] side_b, [95:64] side_c
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;       // [31:0] tri_area
    logic        m_tuser;       // [0] degenerate

    area_scoreboard board;
    logic no_idle;              // long stretch with both sides always busy
    int   cycles;

    spherical_triangle_area_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, none during the no_idle stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 32);
        end
    end

    // Sample on the edge: values seen here are the pre-edge ones
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One input transfer, with random idle cycles before it
    task automatic send_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        while (!no_idle && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        do @(posedge aclk); while (!s_tready);
        board.note_input({c, b, a});
    endtask

    // Mostly valid triangles on the sphere, the rest arbitrary bit patterns
    task automatic send_random();
        logic [31:0] a, b, c;
        longint lo, hi, top;
        if ($urandom_range(99) < 30) begin
            send_triangle($urandom, $urandom, $urandom);
        end else begin
            top = ($urandom_range(3) == 0) ? SIDE_PI : (SIDE_PI >> $urandom_range(10, 1));
            a = $urandom_range(top[31:0], 1);
            b = $urandom_range(top[31:0], 1);
            lo = (a > b) ? a - b : b - a;
            hi = longint'(a) + b;
            if (hi > 2 * SIDE_PI - hi) hi = 2 * SIDE_PI - hi;
            if (hi < lo) hi = lo;
            c = $urandom_range(hi[31:0], lo[31:0]);
            send_triangle(a, b, c);
        end
    endtask

    // Write the threshold only while nothing is in flight
    task automatic drain_and_write(logic [31:0] value);
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.threshold = value;
    endtask

    initial begin
        logic [31:0] limits [PHASES];
        int waited;
        board     = new();
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        no_idle   = 1'b0;
        cycles    = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, collinear and inequality-breaking sides, big triangles
        send_triangle(32'd0, 32'd0, 32'd0);
        send_triangle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_triangle(32'd1, 32'd1, 32'd1);
        send_triangle(32'h0010_0000, 32'h0010_0000, 32'h0010_0000);
        send_triangle(32'd1686629713, 32'd1686629713, 32'd1686629713);   // octant
        send_triangle(SIDE_PI[31:0], SIDE_PI[31:0], SIDE_PI[31:0]);
        send_triangle(32'd2248839617, 32'd2248839617, 32'd2248839617);   // near a great circle
        send_triangle(32'h2000_0000, 32'h2000_0000, 32'h4000_0000);      // collinear
        send_triangle(32'h2000_0000, 32'h2000_0000, 32'h3FFF_FF00);      // sliver
        send_triangle(32'h1000_0000, 32'h1000_0000, 32'h8000_0000);      // inequality broken
        send_triangle(32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
        send_triangle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_triangle(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_triangle(SIDE_PI[31:0], 32'd0, SIDE_PI[31:0]);
        send_triangle(32'h4000_0000, 32'h6000_0000, 32'h3000_0000);
        send_triangle(32'h0000_4000, 32'h0000_4000, 32'h0000_4000);
        send_triangle(32'hC000_0000, 32'hC000_0000, 32'h1000_0000);

        // Threshold sweep: reset value, zero, max, mid, random, back to one
        limits = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'h0010_0000, $urandom, 32'd1};
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) drain_and_write(limits[p]);
            for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
                no_idle = (p == 3 && n >= 20 && n < 90);
                send_random();
            end
            no_idle = 1'b0;
        end
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        waited = 0;
        while (waited < LATENCY + 50) begin
            @(posedge aclk);
            waited++;
        end
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
